### hdl/rrud_pkg.sv
// ----------------------------------------------------------------------------
// rrud_pkg
// shared types and constants of the round robin unit dispatcher
// ----------------------------------------------------------------------------
package rrud_pkg;

    localparam int MAX_UNITS = 16;
    localparam int SLOT_W    = $clog2(MAX_UNITS);
    localparam int COUNT_W   = $clog2(MAX_UNITS + 1);
    localparam int ID_W      = 16;
    localparam int TASK_W    = 16;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_MARK_AV  = 2'd2,
        MODE_MARK_MT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        UNIT_AVAILABLE = 2'd0,
        UNIT_BUSY      = 2'd1,
        UNIT_MAINT     = 2'd2
    } unit_state_t;

    typedef enum logic [2:0] {
        RES_OK       = 3'd0,
        RES_EMPTY    = 3'd1,
        RES_NONE     = 3'd2,
        RES_NOTFOUND = 3'd3,
        RES_FULL     = 3'd4
    } result_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_ADD,
        FSM_SCAN,
        FSM_RESP
    } fsm_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [1:0]        state;
        logic [TASK_W-1:0] tasks;
    } entry_t;

endpackage

### hdl/round_robin_unit_dispatcher.sv
// ----------------------------------------------------------------------------
// round_robin_unit_dispatcher
// ring of worker entries held in an entry memory and a link memory, with
// add, round robin dispatch and mark operations, one result word per input
// ----------------------------------------------------------------------------
// order: a full ring (add) or an empty ring (dispatch, mark) goes straight to the response;
//   an add writes the new entry and its link first; dispatch and mark scan ring entries
//   (one per cycle through the registered memory read) up to a hit or MAX_UNITS entries
// throughput: one word in flight, next word taken once the result is registered
// reset: pointers, unit count and handshake state cleared; memories not cleared
// ----------------------------------------------------------------------------
module round_robin_unit_dispatcher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] unit_id
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] status, [18:3] chosen_id, [34:19] task_total
);

    rrud_pkg::entry_t entry_mem [rrud_pkg::MAX_UNITS];
    logic [rrud_pkg::SLOT_W-1:0] link_mem [rrud_pkg::MAX_UNITS];

    rrud_pkg::fsm_t state_reg, state_next;

    logic [rrud_pkg::SLOT_W-1:0]  rot_reg, rot_next;
    logic [rrud_pkg::SLOT_W-1:0]  tail_reg, tail_next;
    logic [rrud_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rrud_pkg::SLOT_W-1:0]  cur_reg, cur_next;
    logic [rrud_pkg::COUNT_W-1:0] tried_reg, tried_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [rrud_pkg::ID_W-1:0]    id_reg, id_next;

    logic [2:0]                   res_status_reg, res_status_next;
    logic [rrud_pkg::ID_W-1:0]    res_id_reg, res_id_next;
    logic [rrud_pkg::TASK_W-1:0]  res_tasks_reg, res_tasks_next;

    logic                         m_valid_reg, m_valid_next;
    logic [39:0]                  m_data_reg, m_data_next;

    rrud_pkg::entry_t             rd_entry;
    logic [rrud_pkg::SLOT_W-1:0]  rd_link;
    logic [rrud_pkg::SLOT_W-1:0]  rd_addr;

    logic                         ent_we;
    logic [rrud_pkg::SLOT_W-1:0]  ent_waddr;
    rrud_pkg::entry_t             ent_wdata;
    logic                         lnk_we;
    logic [rrud_pkg::SLOT_W-1:0]  lnk_waddr;
    logic [rrud_pkg::SLOT_W-1:0]  lnk_wdata;

    logic                         accept;
    logic                         full;
    logic                         hit;
    logic                         last_try;
    logic [rrud_pkg::SLOT_W-1:0]  new_slot;
    logic [rrud_pkg::TASK_W-1:0]  tasks_inc;

    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == rrud_pkg::COUNT_W'(rrud_pkg::MAX_UNITS));
    assign new_slot  = count_reg[rrud_pkg::SLOT_W-1:0];
    assign last_try  = (rrud_pkg::COUNT_W'(tried_reg + 1'b1) == count_reg);
    assign tasks_inc = (rd_entry.tasks == '1) ? rd_entry.tasks
                                              : rd_entry.tasks + 1'b1;
    assign hit       = (mode_reg == rrud_pkg::MODE_DISPATCH)
                       ? (rd_entry.state == rrud_pkg::UNIT_AVAILABLE)
                       : (rd_entry.id == id_reg);
    assign rd_addr   = (state_reg == rrud_pkg::FSM_IDLE) ? rot_reg : rd_link;

    assign s_tready  = (state_reg == rrud_pkg::FSM_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // memories
    always_ff @(posedge aclk) begin
        rd_entry <= entry_mem[rd_addr];
        rd_link  <= link_mem[rd_addr];
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (lnk_we) begin
            link_mem[lnk_waddr] <= lnk_wdata;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrud_pkg::FSM_IDLE: begin
                if (accept) begin
                    if (s_tuser == rrud_pkg::MODE_ADD) begin
                        state_next = full ? rrud_pkg::FSM_RESP : rrud_pkg::FSM_ADD;
                    end else begin
                        state_next = (count_reg == '0) ? rrud_pkg::FSM_RESP
                                                       : rrud_pkg::FSM_SCAN;
                    end
                end
            end
            rrud_pkg::FSM_ADD: begin
                state_next = rrud_pkg::FSM_RESP;
            end
            rrud_pkg::FSM_SCAN: begin
                if (hit || last_try) begin
                    state_next = rrud_pkg::FSM_RESP;
                end
            end
            rrud_pkg::FSM_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = rrud_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = rrud_pkg::FSM_IDLE;
            end
        endcase
    end

    // datapath and memory writes
    always_comb begin
        rot_next        = rot_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        tried_next      = tried_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_tasks_next  = res_tasks_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ent_we          = 1'b0;
        ent_waddr       = cur_reg;
        ent_wdata       = rd_entry;
        lnk_we          = 1'b0;
        lnk_waddr       = tail_reg;
        lnk_wdata       = new_slot;
        case (state_reg)
            rrud_pkg::FSM_IDLE: begin
                if (accept) begin
                    mode_next       = s_tuser;
                    id_next         = s_tdata;
                    cur_next        = rot_reg;
                    tried_next      = '0;
                    res_id_next     = '0;
                    res_tasks_next  = '0;
                    if (s_tuser == rrud_pkg::MODE_ADD) begin
                        res_status_next = full ? rrud_pkg::RES_FULL : rrud_pkg::RES_OK;
                        // link old tail to the new slot
                        lnk_we = !full;
                    end else begin
                        res_status_next = rrud_pkg::RES_EMPTY;
                    end
                end
            end
            rrud_pkg::FSM_ADD: begin
                ent_we          = 1'b1;
                ent_waddr       = new_slot;
                ent_wdata.id    = id_reg;
                ent_wdata.state = rrud_pkg::UNIT_AVAILABLE;
                ent_wdata.tasks = '0;
                lnk_we          = 1'b1;
                lnk_waddr       = new_slot;
                lnk_wdata       = (count_reg == '0) ? new_slot : rot_reg;
                if (count_reg == '0) begin
                    rot_next = new_slot;
                end
                tail_next  = new_slot;
                count_next = rrud_pkg::COUNT_W'(count_reg + 1'b1);
            end
            rrud_pkg::FSM_SCAN: begin
                if (hit) begin
                    ent_we          = 1'b1;
                    res_status_next = rrud_pkg::RES_OK;
                    if (mode_reg == rrud_pkg::MODE_DISPATCH) begin
                        ent_wdata.state = rrud_pkg::UNIT_BUSY;
                        ent_wdata.tasks = tasks_inc;
                        res_id_next     = rd_entry.id;
                        res_tasks_next  = tasks_inc;
                        tail_next       = cur_reg;
                        rot_next        = rd_link;
                    end else if (mode_reg == rrud_pkg::MODE_MARK_AV) begin
                        ent_wdata.state = rrud_pkg::UNIT_AVAILABLE;
                    end else begin
                        ent_wdata.state = rrud_pkg::UNIT_MAINT;
                    end
                end else if (last_try) begin
                    res_status_next = (mode_reg == rrud_pkg::MODE_DISPATCH)
                                      ? rrud_pkg::RES_NONE : rrud_pkg::RES_NOTFOUND;
                end else begin
                    cur_next   = rd_link;
                    tried_next = rrud_pkg::COUNT_W'(tried_reg + 1'b1);
                end
            end
            rrud_pkg::FSM_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, res_tasks_reg, res_id_reg, res_status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrud_pkg::FSM_IDLE;
            rot_reg     <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rot_reg     <= rot_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        tried_reg      <= tried_next;
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_tasks_reg  <= res_tasks_next;
        m_data_reg     <= m_data_next;
    end

endmodule
